FILE: hw/rtl/c2s_pkg.sv
// Shared types, constants and arctangent table for the Cartesian-to-spherical converter.
package c2s_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ACC_W = 64;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [37:0] PI36 = 38'(PI_Q60 >> 24);
  localparam logic [16:0] HALF_TURN = 17'd46080;
  localparam logic [16:0] FULL_TURN = 17'd92160;

  // Reciprocal of PI36 scaled by 2^69, for the degree quotient estimate.
  localparam logic [31:0] DEG_RECIP = 32'((70'd1 << 69) / 70'(PI36));
  // Register stages in the radian-to-degree unit.
  localparam int DEG_STAGES = 4;

  // Results that bypass the angle pipeline.
  localparam logic [1:0] SP_NORMAL = 2'd0;
  localparam logic [1:0] SP_ORIGIN = 2'd1;
  localparam logic [1:0] SP_ZAXIS  = 2'd2;

  // atan(2^-i) in radians, Q60, from the truncated alternating series.
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = 64'd0;
    if (i == 0) begin
      acc = PI_Q60 >> 2;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  // Sideband that travels with each point down the chain.
  typedef struct packed {
    logic        valid;
    logic [1:0]  special;
    logic        z_neg;
  } c2s_tag_t;

endpackage

FILE: hw/rtl/c2s_sqrt_cell.sv
// One cell of the pipelined square root: settles one result bit per cycle while en is high.
module c2s_sqrt_cell import c2s_pkg::*; #(
  parameter int W   = 66,
  parameter int BIT = 0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] res_i,
  output logic [W-1:0] rem_r,
  output logic [W-1:0] res_r
);
  localparam logic [W-1:0] ONE_BIT = W'(1) << (2 * BIT);
  logic [W-1:0] trial;
  assign trial = res_i + ONE_BIT;
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_i >= trial) begin
        rem_r <= rem_i - trial;
        res_r <= (res_i >> 1) + ONE_BIT;
      end else begin
        rem_r <= rem_i;
        res_r <= res_i >> 1;
      end
    end
  end
endmodule

FILE: hw/rtl/c2s_cordic_cell.sv
// One CORDIC vectoring cell: rotate the vector by +/- atan(2^-STAGE).
module c2s_cordic_cell import c2s_pkg::*; #(
  parameter int W     = 34,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  px_i,
  input  logic signed [W-1:0]  py_i,
  input  logic signed [63:0]   acc_i,
  output logic signed [W-1:0]  px_r,
  output logic signed [W-1:0]  py_r,
  output logic signed [63:0]   acc_r
);
  localparam logic [63:0] ATAN = atan_q60(STAGE);
  logic signed [W-1:0] xs, ys;
  assign xs = px_i >>> STAGE;
  assign ys = py_i >>> STAGE;
  always_ff @(posedge clk) begin
    if (en) begin
      if (py_i > 0) begin
        px_r  <= px_i + ys;
        py_r  <= py_i - xs;
        acc_r <= acc_i + $signed(ATAN);
      end else begin
        px_r  <= px_i - ys;
        py_r  <= py_i + xs;
        acc_r <= acc_i - $signed(ATAN);
      end
    end
  end
endmodule

FILE: hw/rtl/c2s_to_deg.sv
// Angle in radians (Q60) to rounded degrees, four register stages.
module c2s_to_deg import c2s_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] ang_i,
  output logic [16:0]        deg_r
);
  // a36 < 2^39 for angles below 2*pi; scaled numerator below 2^55.
  logic [38:0] a36;
  logic [54:0] a55;
  logic [54:0] num_r, num2_r, num3_r;
  logic [63:0] est;
  logic [16:0] qe_r, qe3_r;
  logic [35:0] ph_r, pl_r;
  logic [54:0] rem;
  assign a36 = ang_i[63] ? 39'd0 : ang_i[62:24];
  assign a55 = 55'(a36);
  // Reciprocal estimate is never high and at most one low.
  assign est = 64'(num_r[54:23]) * 64'(DEG_RECIP);
  assign rem = num3_r - ((55'(ph_r) << 19) + 55'(pl_r));
  always_ff @(posedge clk) begin
    if (en) begin
      // 46080 = 45 * 1024: shift-add scale plus half a divisor for rounding
      num_r  <= (a55 << 15) + (a55 << 13) + (a55 << 12) + (a55 << 10)
                + 55'(PI36 >> 1);
      num2_r <= num_r;
      qe_r   <= est[62:46];
      ph_r   <= 36'(qe_r) * 36'(PI36[37:19]);
      pl_r   <= 36'(qe_r) * 36'(PI36[18:0]);
      num3_r <= num2_r;
      qe3_r  <= qe_r;
      deg_r  <= (rem >= 55'(PI36)) ? qe3_r + 17'd1 : qe3_r;
    end
  end
endmodule

FILE: hw/rtl/cartesian_to_spherical.sv
// Top level of the Cartesian-to-spherical converter.
// Converts one signed Q8.8 point (x, y, z) per clock into radius (unsigned Q8.8), polar angle
// from +z and azimuth from +x (degrees, Q8.8/Q9.8, rounded to nearest). The work
// runs down a row of cells: a square-root chain (one result bit a cell) for the
// radius and the xy projection, then two parallel CORDIC chains of ANGLE_ITERATIONS
// cells, then a four-stage radian-to-degree unit. A new transaction is taken every
// cycle while the skid register is empty. A stall at the output first fills the skid
// register; once it is full the whole chain freezes and the input is held off until
// the skid drains.
module cartesian_to_spherical import c2s_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // coord_x[15:0], coord_y[31:16], coord_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata  // radius[15:0], polar_deg[31:16], azimuth_deg[48:32]
);
  localparam int CW  = COORD_WIDTH;
  localparam int SH  = (31 - COORD_WIDTH) < 0 ? 0 : 31 - COORD_WIDTH;
  localparam int SQW = 2 * CW + 2;          // squared sums
  localparam int RW  = 2 * (CW + SH) + 2;   // scaled xy square
  localparam int RN  = (RW + 1) / 2;
  localparam int NS  = RN;                  // sqrt chain length
  localparam int VW  = CW + SH + 3;         // CORDIC width
  localparam int NA  = ANGLE_ITERATIONS;
  localparam int DEPTH = NS + NA + 1 + DEG_STAGES;

  // Whole pipeline advances together; stalled only when the skid is full.
  logic adv;
  logic skid_full_r;
  logic [55:0] skid_r;
  logic [DEPTH-1:0] vld_r;

  assign adv = !skid_full_r;
  assign in_tready = adv;

  // Stage 0: squares and specials.
  logic signed [CW-1:0] x, y, z;
  assign x = in_tdata[15:0];
  assign y = in_tdata[31:16];
  assign z = in_tdata[47:32];
  logic [RW-1:0] sum_r, rxy_r;
  logic signed [CW-1:0] x0_r, y0_r, z0_r;
  c2s_tag_t tag0_r;
  logic [2*CW:0] rxy2;
  logic [SQW-1:0] sum;
  assign rxy2 = (2*CW+1)'(x * x) + (2*CW+1)'(y * y);
  assign sum  = SQW'(rxy2) + SQW'(z * z);
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= RW'(sum);
      rxy_r <= RW'(rxy2) << (2 * SH);
      x0_r <= x; y0_r <= y; z0_r <= z;
      tag0_r.valid <= 1'b1;
      tag0_r.z_neg <= z[CW-1];
      tag0_r.special <= (sum == '0) ? SP_ORIGIN : (rxy2 == '0) ? SP_ZAXIS : SP_NORMAL;
    end
  end

  // Square-root chain; coordinates and tags ride alongside.
  logic [RW-1:0] srem [NS+1], sres [NS+1], rrem [NS+1], rres [NS+1];
  logic signed [CW-1:0] xs_r [NS+1], ys_r [NS+1], zs_r [NS+1];
  c2s_tag_t tags_r [NS+1];
  assign srem[0] = sum_r; assign sres[0] = '0;
  assign rrem[0] = rxy_r; assign rres[0] = '0;
  always_comb begin
    xs_r[0] = x0_r; ys_r[0] = y0_r; zs_r[0] = z0_r;
    tags_r[0] = tag0_r;
  end
  for (genvar i = 0; i < NS; i++) begin : g_sq
    logic [RW-1:0] a_rem, a_res, b_rem, b_res;
    c2s_sqrt_cell #(.W(RW), .BIT(NS-1-i)) u_s (.clk(clk), .en(adv), .rem_i(srem[i]),
      .res_i(sres[i]), .rem_r(a_rem), .res_r(a_res));
    c2s_sqrt_cell #(.W(RW), .BIT(NS-1-i)) u_r (.clk(clk), .en(adv), .rem_i(rrem[i]),
      .res_i(rres[i]), .rem_r(b_rem), .res_r(b_res));
    assign srem[i+1] = a_rem; assign sres[i+1] = a_res;
    assign rrem[i+1] = b_rem; assign rres[i+1] = b_res;
    always_ff @(posedge clk) begin
      if (adv) begin
        xs_r[i+1] <= xs_r[i]; ys_r[i+1] <= ys_r[i]; zs_r[i+1] <= zs_r[i];
        tags_r[i+1] <= tags_r[i];
      end
    end
  end

  // Radius rounding, CORDIC seeds.
  logic [RW-1:0] rr;
  logic [15:0] rad_c;
  assign rr = sres[NS];
  always_comb begin
    logic [RW-1:0] rnd;
    rnd = (srem[NS] > rr) ? rr + 1'b1 : rr;
    rad_c = (rnd > RW'(16'hFFFF)) ? 16'hFFFF : rnd[15:0];
  end
  logic signed [VW-1:0] pxp [NA+1], pyp [NA+1], pxa [NA+1], pya [NA+1];
  logic signed [63:0] accp [NA+1], acca [NA+1];
  logic [15:0] rad_d_r [NA+1];
  c2s_tag_t tagc_r [NA+1];
  logic signed [VW-1:0] sx, sy;
  assign sx = VW'(xs_r[NS]) <<< SH;
  assign sy = VW'(ys_r[NS]) <<< SH;
  // Polar chain starts from the root of the scaled xy square and -z.
  always_comb begin
    pxp[0] = VW'(rres[NS]);
    pyp[0] = -(VW'(zs_r[NS]) <<< SH);
    accp[0] = $signed(PI_Q60 >> 1);
    pxa[0] = sx[VW-1] ? -sx : sx;
    pya[0] = sx[VW-1] ? -sy : sy;
    acca[0] = sx[VW-1] ? $signed(PI_Q60) : 64'sd0;
    rad_d_r[0] = rad_c;
    tagc_r[0] = tags_r[NS];
  end
  for (genvar i = 0; i < NA; i++) begin : g_cd
    c2s_cordic_cell #(.W(VW), .STAGE(i)) u_p (.clk(clk), .en(adv), .px_i(pxp[i]),
      .py_i(pyp[i]), .acc_i(accp[i]), .px_r(pxp[i+1]), .py_r(pyp[i+1]),
      .acc_r(accp[i+1]));
    c2s_cordic_cell #(.W(VW), .STAGE(i)) u_a (.clk(clk), .en(adv), .px_i(pxa[i]),
      .py_i(pya[i]), .acc_i(acca[i]), .px_r(pxa[i+1]), .py_r(pya[i+1]),
      .acc_r(acca[i+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_d_r[i+1] <= rad_d_r[i]; tagc_r[i+1] <= tagc_r[i];
      end
    end
  end
  // Wrap azimuth into [0, 2pi).
  logic signed [63:0] az_w;
  always_comb begin
    az_w = acca[NA];
    if (az_w < 0) az_w = az_w + $signed(PI_Q60 << 1);
    if (az_w >= $signed(PI_Q60 << 1)) az_w = az_w - $signed(PI_Q60 << 1);
  end
  logic [16:0] pdeg, adeg;
  c2s_to_deg u_pd (.clk(clk), .en(adv), .ang_i(accp[NA]), .deg_r(pdeg));
  c2s_to_deg u_ad (.clk(clk), .en(adv), .ang_i(az_w), .deg_r(adeg));
  logic [15:0] rad_e_r [DEG_STAGES];
  c2s_tag_t tage_r [DEG_STAGES];
  always_ff @(posedge clk) begin
    if (adv) begin
      rad_e_r[0] <= rad_d_r[NA]; tage_r[0] <= tagc_r[NA];
      for (int k = 1; k < DEG_STAGES; k++) begin
        rad_e_r[k] <= rad_e_r[k-1]; tage_r[k] <= tage_r[k-1];
      end
    end
  end
  logic [55:0] res;
  always_comb begin
    logic [16:0] p, a;
    p = (pdeg > HALF_TURN) ? HALF_TURN : pdeg;
    a = (adeg >= FULL_TURN) ? adeg - FULL_TURN : adeg;
    unique case (tage_r[DEG_STAGES-1].special)
      SP_ORIGIN: begin p = '0; a = '0; end
      SP_ZAXIS:  begin p = tage_r[DEG_STAGES-1].z_neg ? HALF_TURN : '0; a = '0; end
      default: ;
    endcase
    res = {7'd0, a, p[15:0], rad_e_r[DEG_STAGES-1]};
  end

  // Validity shift line; one plain register stage for each register stage of the data path.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) skid_full_r <= 1'b0;
    else if (out_tready) skid_full_r <= 1'b0;
    else if (vld_r[DEPTH-1] && !skid_full_r) skid_full_r <= 1'b1;
  end
  always_ff @(posedge clk) if (!skid_full_r) skid_r <= res;
  assign out_tvalid = skid_full_r || vld_r[DEPTH-1];
  assign out_tdata  = skid_full_r ? skid_r : res;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_tvalid) else $error("skid holds without valid");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_full_r |-> in_tready) else $error("input stalled with empty skid");
endmodule

FILE: tb/sv/cartesian_to_spherical_tb.sv
// Self-checking testbench for the Cartesian-to-spherical converter.
module cartesian_to_spherical_tb;
  import c2s_pkg::*;

  typedef struct packed {
    logic [16:0] azim;
    logic [15:0] polar;
    logic [15:0] radius;
  } sph_t;

  typedef struct {
    logic [15:0] x, y, z;
    bit          typed;
    sph_t        res;
  } row_t;

  localparam longint unsigned PI_RAD = 64'h3243F6A8885A308D;
  localparam int STAGES = 16;
  localparam int SCALE_SH = 15;
  localparam int LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;

  longint unsigned atan_rad[32];
  sph_t spherical_q[$];
  row_t typed_q[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  cartesian_to_spherical dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arctangent constants from the alternating series, Q60 radians.
  initial begin
    longint unsigned acc;
    int e;
    atan_rad[0] = PI_RAD >> 2;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          if (k % 2) acc = acc - ((64'd1 << (60 - e)) / (2 * k + 1));
          else acc = acc + ((64'd1 << (60 - e)) / (2 * k + 1));
        end
      end
      atan_rad[i] = acc;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint rotate_angle(longint px, longint py, longint start);
    longint acc, nx, ny;
    acc = start;
    for (int i = 0; i < STAGES; i++) begin
      if (py > 0) begin
        nx = px + (py >>> i);
        ny = py - (px >>> i);
        acc = acc + longint'(atan_rad[i]);
      end else begin
        nx = px - (py >>> i);
        ny = py + (px >>> i);
        acc = acc - longint'(atan_rad[i]);
      end
      px = nx;
      py = ny;
    end
    return acc;
  endfunction

  function automatic longint unsigned rad_to_deg(longint a);
    longint unsigned p36;
    p36 = PI_RAD >> 24;
    if (a < 0) a = 0;
    return ((longint'(unsigned'(a)) >> 24) * 46080 + p36 / 2) / p36;
  endfunction

  function automatic sph_t to_spherical(logic [47:0] d);
    longint x, y, z, px, py, start, a, rxy, pi;
    longint unsigned rxy2, sum, r, polar, azim;
    sph_t s;
    pi = longint'(PI_RAD);
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32]));
    rxy2 = x * x + y * y;
    sum = rxy2 + z * z;
    r = int_sqrt(sum);
    if (sum - r * r > r) r++;
    if (r > 65535) r = 65535;
    if (sum == 0) begin
      polar = 0;
      azim = 0;
    end else if (rxy2 == 0) begin
      polar = (z > 0) ? 0 : 46080;
      azim = 0;
    end else begin
      rxy = longint'(int_sqrt(rxy2 << (2 * SCALE_SH)));
      a = rotate_angle(rxy, -(z <<< SCALE_SH), pi >>> 1);
      polar = rad_to_deg(a);
      if (polar > 46080) polar = 46080;
      px = x <<< SCALE_SH;
      py = y <<< SCALE_SH;
      start = 0;
      if (px < 0) begin
        px = -px;
        py = -py;
        start = pi;
      end
      a = rotate_angle(px, py, start);
      if (a < 0) a = a + 2 * pi;
      if (a >= 2 * pi) a = a - 2 * pi;
      azim = rad_to_deg(a);
      if (azim >= 92160) azim = azim - 92160;
    end
    s.radius = r[15:0];
    s.polar = polar[15:0];
    s.azim = azim[16:0];
    return s;
  endfunction

  // Predict on every accepted input transaction, check every accepted output one.
  always @(posedge clk) begin
    row_t rw;
    sph_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rw = typed_q.pop_front();
        spherical_q.push_back(rw.typed ? rw.res : to_spherical(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = sph_t'(out_tdata[48:0]);
        if (spherical_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = spherical_q.pop_front();
          if (got.radius !== want.radius || got.polar !== want.polar ||
              got.azim !== want.azim) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp r=%0d p=%0d a=%0d got r=%0d p=%0d a=%0d",
                       want.radius, want.polar, want.azim,
                       got.radius, got.polar, got.azim);
          end
        end
      end
    end
  end

  // Receiver: a long hold-off when asked, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one point; return at the falling edge after it is taken.
  task automatic send_point(row_t rw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_q.push_back(rw);
    in_tvalid <= 1'b1;
    in_tdata <= {rw.z, rw.y, rw.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic row_t mk(logic [15:0] x, y, z, bit typed = 1'b0,
                              logic [15:0] r = '0, logic [15:0] p = '0);
    row_t rw;
    rw.x = x; rw.y = y; rw.z = z; rw.typed = typed;
    rw.res.radius = r; rw.res.polar = p; rw.res.azim = '0;
    return rw;
  endfunction

  initial begin
    row_t dir[$];
    row_t rw;
    int kind;
    // origin and the z axis have results that need no computation
    dir.push_back(mk(16'h0000, 16'h0000, 16'h0000, 1, 16'd0, 16'd0));
    dir.push_back(mk(16'h0000, 16'h0000, 16'h0100, 1, 16'd256, 16'd0));
    dir.push_back(mk(16'h0000, 16'h0000, 16'hFF00, 1, 16'd256, 16'd46080));
    dir.push_back(mk(16'h0000, 16'h0000, 16'h7FFF, 1, 16'd32767, 16'd0));
    dir.push_back(mk(16'h0000, 16'h0000, 16'h8000, 1, 16'd32768, 16'd46080));
    dir.push_back(mk(16'h0000, 16'h0000, 16'h0001, 1, 16'd1, 16'd0));
    // axes, quadrants, full-scale corners and an azimuth near the full turn
    dir.push_back(mk(16'h0100, 16'h0000, 16'h0000));
    dir.push_back(mk(16'hFF00, 16'h0000, 16'h0000));
    dir.push_back(mk(16'h0000, 16'h0100, 16'h0000));
    dir.push_back(mk(16'h0000, 16'hFF00, 16'h0000));
    dir.push_back(mk(16'h0100, 16'h0100, 16'h0100));
    dir.push_back(mk(16'hFF00, 16'h0100, 16'hFF00));
    dir.push_back(mk(16'hFF00, 16'hFF00, 16'h0100));
    dir.push_back(mk(16'h7FFF, 16'h7FFF, 16'h7FFF));
    dir.push_back(mk(16'h8000, 16'h8000, 16'h8000));
    dir.push_back(mk(16'h7FFF, 16'h8000, 16'h7FFF));
    dir.push_back(mk(16'h8000, 16'h7FFF, 16'h8000));
    dir.push_back(mk(16'h7FFF, 16'hFFFF, 16'h0000));
    dir.push_back(mk(16'h0001, 16'hFFFF, 16'h0000));
    dir.push_back(mk(16'hFFFF, 16'h0000, 16'h0001));
    dir.push_back(mk(16'h0001, 16'h0001, 16'h8000));
    dir.push_back(mk(16'h8000, 16'h0001, 16'h0000));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir[i]) send_point(dir[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_cycles = 300; end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int n = 0; n < 400; n++) begin
        kind = $urandom_range(0, 9);
        rw = mk(16'($urandom), 16'($urandom), 16'($urandom));
        if (kind == 0) begin
          rw.x = '0; rw.y = '0;
        end else if (kind == 1) begin
          rw.x = 16'($signed($urandom_range(0, 16)) - 8);
          rw.y = 16'($signed($urandom_range(0, 16)) - 8);
          rw.z = 16'($signed($urandom_range(0, 16)) - 8);
        end
        send_point(rw);
      end
    end
    in_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    // drain what is still in the chain
    while (spherical_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: cartesian_to_spherical.f
hw/rtl/c2s_pkg.sv
hw/rtl/c2s_sqrt_cell.sv
hw/rtl/c2s_cordic_cell.sv
hw/rtl/c2s_to_deg.sv
hw/rtl/cartesian_to_spherical.sv
tb/sv/cartesian_to_spherical_tb.sv
